@@ sv/mtnc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtnc_pkg
// types, command codes, block codes and error codes of the markup tag
// nesting checker
// ----------------------------------------------------------------------------
package mtnc_pkg;

   typedef logic [5:0] cmd_type;
   typedef logic [7:0] char_type;
   typedef logic [3:0] err_type;
   typedef logic [3:0] blk_type;
   typedef logic [6:0] fmt_type;

   // tag event codes
   localparam cmd_type CMD_FRAME     = 6'd0;
   localparam cmd_type CMD_H1_OPEN   = 6'd1;
   localparam cmd_type CMD_H1_CLOSE  = 6'd2;
   localparam cmd_type CMD_H2_OPEN   = 6'd3;
   localparam cmd_type CMD_H2_CLOSE  = 6'd4;
   localparam cmd_type CMD_H3_OPEN   = 6'd5;
   localparam cmd_type CMD_H3_CLOSE  = 6'd6;
   localparam cmd_type CMD_H4_OPEN   = 6'd7;
   localparam cmd_type CMD_H4_CLOSE  = 6'd8;
   localparam cmd_type CMD_H5_OPEN   = 6'd9;
   localparam cmd_type CMD_H5_CLOSE  = 6'd10;
   localparam cmd_type CMD_P_OPEN    = 6'd11;
   localparam cmd_type CMD_P_CLOSE   = 6'd12;
   localparam cmd_type CMD_PRE_OPEN  = 6'd13;
   localparam cmd_type CMD_PRE_CLOSE = 6'd14;
   localparam cmd_type CMD_BR        = 6'd15;
   localparam cmd_type CMD_B_OPEN    = 6'd16;
   localparam cmd_type CMD_B_CLOSE   = 6'd17;
   localparam cmd_type CMD_I_OPEN    = 6'd18;
   localparam cmd_type CMD_I_CLOSE   = 6'd19;
   localparam cmd_type CMD_U_OPEN    = 6'd20;
   localparam cmd_type CMD_U_CLOSE   = 6'd21;
   localparam cmd_type CMD_SUB_OPEN  = 6'd22;
   localparam cmd_type CMD_SUB_CLOSE = 6'd23;
   localparam cmd_type CMD_SUP_OPEN  = 6'd24;
   localparam cmd_type CMD_SUP_CLOSE = 6'd25;
   localparam cmd_type CMD_SPAN_OPEN = 6'd26;
   localparam cmd_type CMD_SPAN_CLOSE= 6'd27;
   localparam cmd_type CMD_A_LINK    = 6'd28;
   localparam cmd_type CMD_A_NAME    = 6'd29;
   localparam cmd_type CMD_A_CLOSE   = 6'd30;
   localparam cmd_type CMD_OL_OPEN   = 6'd31;
   localparam cmd_type CMD_OL_CLOSE  = 6'd32;
   localparam cmd_type CMD_UL_OPEN   = 6'd33;
   localparam cmd_type CMD_UL_CLOSE  = 6'd34;
   localparam cmd_type CMD_LI_OPEN   = 6'd35;
   localparam cmd_type CMD_LI_CLOSE  = 6'd36;
   localparam cmd_type CMD_IMG       = 6'd37;
   localparam cmd_type CMD_COMPLETE  = 6'd38;

   // block codes
   localparam blk_type BLK_NONE = 4'd0;
   localparam blk_type BLK_P    = 4'd6;
   localparam blk_type BLK_PRE  = 4'd7;
   localparam blk_type BLK_OL   = 4'd8;
   localparam blk_type BLK_UL   = 4'd9;

   // error codes
   localparam err_type ERR_OK       = 4'd0;
   localparam err_type ERR_NOBLOCK  = 4'd1;
   localparam err_type ERR_MISMATCH = 4'd2;
   localparam err_type ERR_INBLOCK  = 4'd3;
   localparam err_type ERR_NOTLIST  = 4'd4;
   localparam err_type ERR_NOTITEM  = 4'd5;
   localparam err_type ERR_ITEMOPEN = 4'd6;
   localparam err_type ERR_HASFMT   = 4'd7;
   localparam err_type ERR_NOFMT    = 4'd8;
   localparam err_type ERR_BR       = 4'd9;

   localparam fmt_type FMT_A_MASK = 7'b100_0000;

   typedef struct packed {
      blk_type open_block;
      fmt_type format_flags;
      logic    anchor_name_open;
      logic    list_item_open;
      logic    frame_nonspace_seen;
   } state_type;

   typedef struct packed {
      logic    has_result;
      err_type error_code;
   } eval_type;

endpackage : mtnc_pkg
`default_nettype wire

@@ sv/mtnc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtnc_req_if / mtnc_rsp_if
// valid/ready channels for tag events and error code results
// ----------------------------------------------------------------------------
interface mtnc_req_if;
   logic               valid;
   logic               ready;
   mtnc_pkg::cmd_type  cmd;
   mtnc_pkg::char_type text_char;
   logic               last_char;

   modport source (output valid, cmd, text_char, last_char, input ready);
   modport sink   (input valid, cmd, text_char, last_char, output ready);
endinterface : mtnc_req_if

interface mtnc_rsp_if;
   logic              valid;
   logic              ready;
   mtnc_pkg::err_type error_code;

   modport source (output valid, error_code, input ready);
   modport sink   (input valid, error_code, output ready);
endinterface : mtnc_rsp_if
`default_nettype wire

@@ sv/mtnc_eval.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtnc_eval
// decodes one tag event against the nesting state: next state and error code
// ----------------------------------------------------------------------------
module mtnc_eval (
   input  wire  mtnc_pkg::state_type state_cur,
   input  wire  mtnc_pkg::cmd_type   cmd,
   input  wire  mtnc_pkg::char_type  text_char,
   input  wire                       last_char,
   output mtnc_pkg::state_type       state_nxt,
   output mtnc_pkg::eval_type        result
);
   import mtnc_pkg::*;

   logic    is_space;
   logic    seen;
   logic    in_list;
   logic    block_open;
   logic    fmt_active;
   cmd_type cmd_inc;
   cmd_type cmd_fmt;
   blk_type blk_sel;
   fmt_type fmt_mask;
   err_type close_err;

   always_comb begin
      is_space   = (text_char == 8'h20) || ((text_char >= 8'h09) && (text_char <= 8'h0d));
      seen       = state_cur.frame_nonspace_seen | ~is_space;
      in_list    = (state_cur.open_block == BLK_OL) || (state_cur.open_block == BLK_UL);
      block_open = (state_cur.open_block != BLK_NONE);
      fmt_active = |state_cur.format_flags;
      cmd_inc    = cmd + 6'd1;
      cmd_fmt    = cmd - 6'd16;
      fmt_mask   = 7'b000_0001 << cmd_fmt[3:1];

      // block selected by an open or close tag
      priority if (cmd <= CMD_H5_CLOSE) begin
         blk_sel = cmd_inc[4:1];
      end else if (cmd <= CMD_P_CLOSE) begin
         blk_sel = BLK_P;
      end else if (cmd <= CMD_PRE_CLOSE) begin
         blk_sel = BLK_PRE;
      end else if (cmd <= CMD_OL_CLOSE) begin
         blk_sel = BLK_OL;
      end else begin
         blk_sel = BLK_UL;
      end

      if (state_cur.open_block == blk_sel) begin
         close_err = fmt_active ? ERR_HASFMT : ERR_OK;
      end else if (block_open) begin
         close_err = ERR_MISMATCH;
      end else begin
         close_err = ERR_NOBLOCK;
      end
   end

   always_comb begin
      state_nxt         = state_cur;
      result.has_result = 1'b1;
      result.error_code = ERR_OK;

      unique case (cmd)
         CMD_FRAME: begin
            if (last_char) begin
               result.error_code = (!block_open && seen) ? ERR_NOBLOCK : ERR_OK;
               state_nxt.frame_nonspace_seen = 1'b0;
            end else begin
               result.has_result = 1'b0;
               state_nxt.frame_nonspace_seen = seen;
            end
         end
         CMD_H1_OPEN, CMD_H2_OPEN, CMD_H3_OPEN, CMD_H4_OPEN, CMD_H5_OPEN,
         CMD_P_OPEN, CMD_PRE_OPEN, CMD_OL_OPEN, CMD_UL_OPEN: begin
            if (block_open) begin
               result.error_code = ERR_INBLOCK;
            end else begin
               state_nxt.open_block = blk_sel;
            end
         end
         CMD_H1_CLOSE, CMD_H2_CLOSE, CMD_H3_CLOSE, CMD_H4_CLOSE, CMD_H5_CLOSE,
         CMD_P_CLOSE, CMD_PRE_CLOSE: begin
            result.error_code = close_err;
            if (state_cur.open_block == blk_sel) begin
               state_nxt.open_block = BLK_NONE;
            end
         end
         CMD_OL_CLOSE, CMD_UL_CLOSE: begin
            if (state_cur.list_item_open) begin
               result.error_code = ERR_ITEMOPEN;
            end else begin
               result.error_code = close_err;
               if (state_cur.open_block == blk_sel) begin
                  state_nxt.open_block = BLK_NONE;
               end
            end
         end
         CMD_BR: begin
            result.error_code = ERR_BR;
         end
         CMD_B_OPEN, CMD_I_OPEN, CMD_U_OPEN, CMD_SUB_OPEN, CMD_SUP_OPEN,
         CMD_SPAN_OPEN, CMD_A_LINK: begin
            if (!block_open) begin
               result.error_code = ERR_NOBLOCK;
            end else if (|(state_cur.format_flags & fmt_mask)) begin
               result.error_code = ERR_HASFMT;
            end else begin
               state_nxt.format_flags = state_cur.format_flags | fmt_mask;
            end
         end
         CMD_B_CLOSE, CMD_I_CLOSE, CMD_U_CLOSE, CMD_SUB_CLOSE, CMD_SUP_CLOSE,
         CMD_SPAN_CLOSE: begin
            if (!(|(state_cur.format_flags & fmt_mask))) begin
               result.error_code = ERR_NOFMT;
            end else begin
               state_nxt.format_flags = state_cur.format_flags & ~fmt_mask;
            end
         end
         CMD_A_NAME: begin
            if (block_open) begin
               result.error_code = ERR_INBLOCK;
            end else if (state_cur.anchor_name_open) begin
               result.error_code = ERR_HASFMT;
            end else begin
               state_nxt.anchor_name_open = 1'b1;
            end
         end
         CMD_A_CLOSE: begin
            if (block_open) begin
               if (!(|(state_cur.format_flags & FMT_A_MASK))) begin
                  result.error_code = ERR_NOFMT;
               end else begin
                  state_nxt.format_flags = state_cur.format_flags & ~FMT_A_MASK;
               end
            end else if (!state_cur.anchor_name_open) begin
               result.error_code = ERR_NOFMT;
            end else begin
               state_nxt.anchor_name_open = 1'b0;
            end
         end
         CMD_LI_OPEN: begin
            if (in_list && !state_cur.list_item_open) begin
               state_nxt.list_item_open = 1'b1;
            end else begin
               result.error_code = ERR_NOTLIST;
            end
         end
         CMD_LI_CLOSE: begin
            if (in_list && state_cur.list_item_open) begin
               state_nxt.list_item_open = 1'b0;
               result.error_code = fmt_active ? ERR_HASFMT : ERR_OK;
            end else begin
               result.error_code = ERR_NOTITEM;
            end
         end
         CMD_IMG, CMD_COMPLETE: begin
            result.error_code = block_open ? ERR_INBLOCK : ERR_OK;
         end
         default: begin
            result.has_result = 1'b0;
         end
      endcase
   end

endmodule : mtnc_eval
`default_nettype wire

@@ sv/markup_tag_nesting_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// markup_tag_nesting_checker
// checks nesting of markup tag events and answers each tag with an error code
// ----------------------------------------------------------------------------
// One tag event is taken per clock cycle while no result is stalled. A
// transaction is registered on the way in and checked against the nesting
// state in the next cycle. Its error code is loaded into the output register
// once that register is free or being taken, and is offered from there. Frame
// text bytes other than the last byte of a string and unused command codes
// give no result. The state update loop sets the rate; a stalled result
// channel holds the pipeline, and the input keeps flowing while the output
// register is free or being taken.
module markup_tag_nesting_checker (
   input  wire          clock,
   input  wire          reset,
   mtnc_req_if.sink     req_bus,
   mtnc_rsp_if.source   rsp_bus
);
   import mtnc_pkg::*;

   logic      s1_valid_ff;
   logic      s1_valid_in;
   cmd_type   s1_cmd_ff;
   char_type  s1_char_ff;
   logic      s1_last_ff;
   state_type state_ff;
   state_type state_in;
   eval_type  eval_res;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   err_type   rsp_code_ff;
   logic      out_free;
   logic      s1_advance;
   logic      req_take;

   mtnc_eval u_eval (
      .state_cur (state_ff),
      .cmd       (s1_cmd_ff),
      .text_char (s1_char_ff),
      .last_char (s1_last_ff),
      .state_nxt (state_in),
      .result    (eval_res)
   );

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_bus.ready;
      s1_advance    = s1_valid_ff && (!eval_res.has_result || out_free);
      req_bus.ready = !s1_valid_ff || s1_advance;
      req_take      = req_bus.valid && req_bus.ready;
      s1_valid_in   = req_take || (s1_valid_ff && !s1_advance);
      rsp_valid_in  = (s1_advance && eval_res.has_result) || (rsp_valid_ff && !rsp_bus.ready);
      rsp_bus.valid      = rsp_valid_ff;
      rsp_bus.error_code = rsp_code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= req_bus.cmd;
         s1_char_ff <= req_bus.text_char;
         s1_last_ff <= req_bus.last_char;
      end
      if (s1_advance && eval_res.has_result) begin
         rsp_code_ff <= eval_res.error_code;
      end
   end

endmodule : markup_tag_nesting_checker
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the markup tag nesting checker. A short table of
// tag events walks the error paths first, then random documents (blocks,
// lists, formats, frame text) mixed with stray tags and unused codes are
// sent. Every accepted tag goes through a local model of the nesting state,
// and each returned error code is compared with the oldest predicted one.
// The sender works in bursts with gaps, and the result side stalls on
// changing patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import mtnc_pkg::*;

   localparam int      ITEM_TARGET    = 1350;
   localparam int      CYCLE_LIMIT    = 400000;
   localparam int      DRAIN_CYCLES   = 8;
   localparam int      REPORT_LIMIT   = 10;
   localparam cmd_type CMD_UNUSED_TOP = 6'd63;
   localparam char_type SPACE_CHAR    = 8'h20;

   typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_PERIODIC, RDY_COIN} ready_mode_type;

   typedef struct packed {
      cmd_type  cmd;
      char_type ch;
      logic     lst;
      logic     typed;
      err_type  code;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   mtnc_req_if req_bus ();
   mtnc_rsp_if rsp_bus ();

   markup_tag_nesting_checker DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // nesting state as the block should hold it
   blk_type nest_block;
   fmt_type nest_fmt;
   logic    name_anchor;
   logic    item_open;
   logic    nonspace_seen;

   err_type        pending_codes[$];
   err_type        expected_code;
   int             code_hits[16];
   int             fail_count;
   int             codes_checked;
   int             tags_sent;
   int             ignored_sent;
   int             burst_left;
   int             cycle_count;
   int             stall_left;
   ready_mode_type stall_mode;

   stim_row_type directed_rows [0:27] = '{
      '{CMD_A_CLOSE,    8'h00, 1'b0, 1'b1, ERR_NOFMT},
      '{CMD_H1_CLOSE,   8'h00, 1'b0, 1'b1, ERR_NOBLOCK},
      '{CMD_B_OPEN,     8'h00, 1'b0, 1'b1, ERR_NOBLOCK},
      '{CMD_LI_OPEN,    8'h00, 1'b0, 1'b1, ERR_NOTLIST},
      '{CMD_LI_CLOSE,   8'h00, 1'b0, 1'b1, ERR_NOTITEM},
      '{CMD_BR,         8'h00, 1'b0, 1'b1, ERR_BR},
      '{CMD_FRAME,      8'h78, 1'b0, 1'b0, ERR_OK},
      '{CMD_A_NAME,     8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_FRAME,      8'h20, 1'b1, 1'b0, ERR_OK},
      '{CMD_A_NAME,     8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_A_CLOSE,    8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_FRAME,      8'hFF, 1'b1, 1'b0, ERR_OK},
      '{CMD_UNUSED_TOP, 8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_H5_OPEN,    8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_P_OPEN,     8'h00, 1'b0, 1'b1, ERR_INBLOCK},
      '{CMD_B_OPEN,     8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_A_LINK,     8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_H1_CLOSE,   8'h00, 1'b0, 1'b1, ERR_MISMATCH},
      '{CMD_H5_CLOSE,   8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_FRAME,      8'h0D, 1'b1, 1'b0, ERR_OK},
      '{CMD_FRAME,      8'h00, 1'b1, 1'b0, ERR_OK},
      '{CMD_OL_OPEN,    8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_LI_OPEN,    8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_LI_OPEN,    8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_OL_CLOSE,   8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_LI_CLOSE,   8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_OL_CLOSE,   8'h00, 1'b0, 1'b0, ERR_OK},
      '{CMD_B_CLOSE,    8'h00, 1'b0, 1'b0, ERR_OK}
   };

   function automatic err_type fmt_code();
      return (nest_fmt != '0) ? ERR_HASFMT : ERR_OK;
   endfunction

   function automatic err_type open_blk(input blk_type target);
      if (nest_block != BLK_NONE) return ERR_INBLOCK;
      nest_block = target;
      return ERR_OK;
   endfunction

   function automatic err_type close_blk(input blk_type target);
      if (nest_block == target) begin
         nest_block = BLK_NONE;
         return fmt_code();
      end
      return (nest_block != BLK_NONE) ? ERR_MISMATCH : ERR_NOBLOCK;
   endfunction

   function automatic err_type set_fmt(input fmt_type mask);
      if (nest_block == BLK_NONE) return ERR_NOBLOCK;
      if ((nest_fmt & mask) != '0) return ERR_HASFMT;
      nest_fmt = nest_fmt | mask;
      return ERR_OK;
   endfunction

   function automatic err_type clear_fmt(input fmt_type mask);
      if ((nest_fmt & mask) == '0) return ERR_NOFMT;
      nest_fmt = nest_fmt & ~mask;
      return ERR_OK;
   endfunction

   // updates the nesting state; returns 1 when the tag is answered
   function automatic logic predict_tag(input cmd_type c, input char_type ch,
                                        input logic lst, output err_type code);
      blk_type target;
      fmt_type mask;
      code = ERR_OK;
      if (c == CMD_FRAME) begin
         if (!(ch == SPACE_CHAR || (ch >= 8'h09 && ch <= 8'h0D))) nonspace_seen = 1'b1;
         if (!lst) return 1'b0;
         code = (nest_block == BLK_NONE && nonspace_seen) ? ERR_NOBLOCK : ERR_OK;
         nonspace_seen = 1'b0;
      end else if (c <= CMD_PRE_CLOSE) begin
         if (c <= CMD_H5_CLOSE) target = blk_type'((c + 1) >> 1);
         else target = (c <= CMD_P_CLOSE) ? BLK_P : BLK_PRE;
         code = c[0] ? open_blk(target) : close_blk(target);
      end else if (c == CMD_BR) begin
         code = ERR_BR;
      end else if (c <= CMD_SPAN_CLOSE) begin
         mask = fmt_type'(1) << ((c - CMD_B_OPEN) >> 1);
         code = c[0] ? clear_fmt(mask) : set_fmt(mask);
      end else if (c == CMD_A_LINK) begin
         code = set_fmt(FMT_A_MASK);
      end else if (c == CMD_A_NAME) begin
         if (nest_block != BLK_NONE) code = ERR_INBLOCK;
         else if (name_anchor) code = ERR_HASFMT;
         else name_anchor = 1'b1;
      end else if (c == CMD_A_CLOSE) begin
         if (nest_block != BLK_NONE) code = clear_fmt(FMT_A_MASK);
         else if (!name_anchor) code = ERR_NOFMT;
         else name_anchor = 1'b0;
      end else if (c <= CMD_UL_CLOSE) begin
         target = (c <= CMD_OL_CLOSE) ? BLK_OL : BLK_UL;
         if (c[0]) code = open_blk(target);
         else if (item_open) code = ERR_ITEMOPEN;
         else code = close_blk(target);
      end else if (c == CMD_LI_OPEN) begin
         if ((nest_block == BLK_OL || nest_block == BLK_UL) && !item_open) item_open = 1'b1;
         else code = ERR_NOTLIST;
      end else if (c == CMD_LI_CLOSE) begin
         if ((nest_block == BLK_OL || nest_block == BLK_UL) && item_open) begin
            item_open = 1'b0;
            code = fmt_code();
         end else begin
            code = ERR_NOTITEM;
         end
      end else if (c <= CMD_COMPLETE) begin
         code = (nest_block != BLK_NONE) ? ERR_INBLOCK : ERR_OK;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic cmd_type close_of(input blk_type blk);
      case (blk)
         BLK_P:   return CMD_P_CLOSE;
         BLK_PRE: return CMD_PRE_CLOSE;
         BLK_OL:  return CMD_OL_CLOSE;
         BLK_UL:  return CMD_UL_CLOSE;
         default: return cmd_type'(2 * blk);
      endcase
   endfunction

   // one tag transaction, with the sender's burst and gap pattern
   task automatic send_tag(input cmd_type c, input char_type ch = 8'h00,
                           input logic lst = 1'b0, input logic typed = 1'b0,
                           input err_type typed_code = ERR_OK);
      int      gap;
      err_type code;
      logic    has_code;
      if (c != CMD_FRAME) begin
         ch  = char_type'($urandom);
         lst = 1'($urandom);
      end
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= c;
      req_bus.text_char <= ch;
      req_bus.last_char <= lst;
      do @(posedge clock); while (!req_bus.ready);
      has_code = predict_tag(c, ch, lst, code);
      if (has_code) pending_codes.push_back(typed ? typed_code : code);
      if (c <= CMD_COMPLETE) tags_sent++;
      else ignored_sent++;
   endtask

   task automatic send_text(input int len);
      char_type ch;
      for (int i = 0; i < len; i++) begin
         // stray tag in the middle of a string
         if (i != 0 && $urandom_range(0, 9) == 0)
            send_tag(cmd_type'($urandom_range(CMD_H1_OPEN, CMD_COMPLETE)));
         case ($urandom_range(0, 3))
            0:       ch = SPACE_CHAR;
            1:       ch = char_type'($urandom_range(8'h09, 8'h0D));
            default: ch = char_type'($urandom_range(0, 255));
         endcase
         send_tag(CMD_FRAME, ch, i == len - 1);
      end
   endtask

   task automatic send_content(input int pieces);
      cmd_type fmt_cmd;
      repeat (pieces) begin
         case ($urandom_range(0, 6))
            0, 1: send_text($urandom_range(1, 6));
            2, 3: begin
               fmt_cmd = cmd_type'(CMD_B_OPEN + 2 * $urandom_range(0, 5));
               send_tag(fmt_cmd);
               send_text($urandom_range(1, 4));
               if ($urandom_range(0, 7) != 0) send_tag(cmd_type'(fmt_cmd + 1));
            end
            4: begin
               send_tag(CMD_A_LINK);
               send_text($urandom_range(1, 4));
               if ($urandom_range(0, 7) != 0) send_tag(CMD_A_CLOSE);
            end
            5: send_tag($urandom_range(0, 1) ? CMD_BR : CMD_IMG);
            default: send_tag(cmd_type'($urandom_range(CMD_H1_OPEN, CMD_COMPLETE)));
         endcase
      end
   endtask

   task automatic clear_formats();
      for (int b = 0; b < 6; b++)
         if (nest_fmt[b]) send_tag(cmd_type'(CMD_B_CLOSE + 2 * b));
      if ((nest_fmt & FMT_A_MASK) != '0 && nest_block != BLK_NONE) send_tag(CMD_A_CLOSE);
   endtask

   task automatic send_block();
      blk_type blk;
      // mostly start from the top level
      if ($urandom_range(0, 7) != 0) begin
         clear_formats();
         if (item_open) send_tag(CMD_LI_CLOSE);
         if (nest_block != BLK_NONE) send_tag(close_of(nest_block));
         if (name_anchor) send_tag(CMD_A_CLOSE);
      end
      blk = blk_type'($urandom_range(1, 9));
      send_tag(cmd_type'(close_of(blk) - 1));
      if (blk == BLK_OL || blk == BLK_UL) begin
         repeat ($urandom_range(0, 4)) begin
            send_tag(CMD_LI_OPEN);
            send_content($urandom_range(0, 4));
            if ($urandom_range(0, 3) != 0) clear_formats();
            if ($urandom_range(0, 9) != 0) send_tag(CMD_LI_CLOSE);
         end
      end else begin
         send_content($urandom_range(0, 6));
      end
      if ($urandom_range(0, 7) != 0) clear_formats();
      if ($urandom_range(0, 7) == 0) begin
         send_tag(close_of(blk_type'($urandom_range(1, 9))));
      end else if ($urandom_range(0, 7) != 0) begin
         if (item_open) send_tag(CMD_LI_CLOSE);
         if (nest_block != BLK_NONE) send_tag(close_of(nest_block));
      end
   endtask

   // result side: the ready pattern is drawn anew whenever the stall counter runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = ready_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         RDY_ALWAYS:   rsp_bus.ready <= 1'b1;
         RDY_MOSTLY:   rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         RDY_PERIODIC: rsp_bus.ready <= (stall_left[2:0] != 3'd0);
         default:      rsp_bus.ready <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_codes.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("error: error_code %0d returned with nothing pending",
                        rsp_bus.error_code);
         end else begin
            expected_code = pending_codes.pop_front();
            codes_checked++;
            code_hits[expected_code]++;
            if (rsp_bus.error_code !== expected_code) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("error: result %0d error_code expected %0d got %0d",
                           codes_checked, expected_code, rsp_bus.error_code);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("error: timeout after %0d cycles, %0d results pending",
                  cycle_count, pending_codes.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_FRAME;
      req_bus.text_char = 8'h00;
      req_bus.last_char = 1'b0;
      rsp_bus.ready     = 1'b0;
      nest_block        = BLK_NONE;
      nest_fmt          = '0;
      name_anchor       = 1'b0;
      item_open         = 1'b0;
      nonspace_seen     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_tag(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].lst,
                  directed_rows[i].typed, directed_rows[i].code);

      while (tags_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: send_block();
            7: begin
               if (nest_block != BLK_NONE && !item_open) send_tag(close_of(nest_block));
               send_tag(CMD_A_NAME);
               send_text($urandom_range(1, 3));
               send_tag(CMD_A_CLOSE);
               send_text($urandom_range(1, 3));
               send_tag($urandom_range(0, 1) ? CMD_COMPLETE : CMD_IMG);
            end
            default: begin
               repeat ($urandom_range(1, 6))
                  send_tag(cmd_type'($urandom_range(0, 63)), char_type'($urandom),
                           1'($urandom));
            end
         endcase
      end
      req_bus.valid <= 1'b0;

      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d tag transactions plus %0d with unused codes, %0d results checked",
               tags_sent, ignored_sent, codes_checked);
      $display("summary: ok %0d, no block %0d, mismatch %0d, in block %0d, not list %0d,",
               code_hits[ERR_OK], code_hits[ERR_NOBLOCK], code_hits[ERR_MISMATCH],
               code_hits[ERR_INBLOCK], code_hits[ERR_NOTLIST],
               " not item %0d, item open %0d, has fmt %0d, no fmt %0d, br %0d",
               code_hits[ERR_NOTITEM], code_hits[ERR_ITEMOPEN], code_hits[ERR_HASFMT],
               code_hits[ERR_NOFMT], code_hits[ERR_BR]);
      if (fail_count == 0 && pending_codes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("error: %0d mismatches, %0d results never returned",
                  fail_count, pending_codes.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule : tb_top

@@ files.f @@
sv/mtnc_pkg.sv
sv/mtnc_if.sv
sv/mtnc_eval.sv
sv/markup_tag_nesting_checker.sv
verif/tb_top.sv
